>>> hw/rtl/ptif_pkg.sv
// Shared types, constants and helper functions of the period timer.
package ptif_pkg;

  localparam int CNT_W    = 16;        // timer counter width
  localparam int CLK_W    = 28;        // clock_hz register width
  localparam int US_W     = 31;        // requested interval width
  localparam int OUT_US_W = 35;        // microsecond result width
  localparam int STEP_W   = 20;        // step in us, at most 1000000
  localparam int DIVD_W   = US_W;      // divider dividend / quotient width
  localparam int DIVS_W   = CLK_W;     // divider divisor width
  localparam int MUL_B_W  = CNT_W + 1; // steps can reach 2**CNT_W
  localparam int MUL_P_W  = STEP_W + MUL_B_W;

  localparam logic [CLK_W-1:0]  CLOCK_HZ_RESET = CLK_W'(40000000);
  localparam logic [DIVD_W-1:0] ONE_MILLION    = DIVD_W'(1000000);
  localparam logic [DIVD_W-1:0] TIMER_SPAN     = DIVD_W'(64'd1 << CNT_W);

  typedef enum logic [2:0] {
    CMD_TICK         = 3'd0,
    CMD_SET_INTERVAL = 3'd1,
    CMD_SET_PRESCALE = 3'd2,
    CMD_START        = 3'd3,
    CMD_STOP         = 3'd4,
    CMD_CLEAR        = 3'd5,
    CMD_READ         = 3'd6,
    CMD_ACK          = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_TBL_START,
    ST_TBL_WAIT,
    ST_IDLE,
    ST_FIT_START,
    ST_FIT_WAIT,
    ST_ACTUAL,
    ST_FALLBACK,
    ST_ELAPSED
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [US_W-1:0]    interval_us;
    logic signed [7:0]  prescaler_sel;
  } in_t;

  typedef struct packed {
    logic [OUT_US_W-1:0] actual_interval_us;
    logic [CNT_W-1:0]    timer_value;
    logic [OUT_US_W-1:0] elapsed_us;
    logic                expired;
    logic [1:0]          prescale_sel_now;
    logic [CNT_W-1:0]    period_now;
  } out_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // prescale ratio 1, 8, 64, 256
  function automatic logic [8:0] prescale_div(logic [1:0] idx);
    logic [8:0] d;
    case (idx)
      2'd0:    d = 9'd1;
      2'd1:    d = 9'd8;
      2'd2:    d = 9'd64;
      default: d = 9'd256;
    endcase
    return d;
  endfunction

  // clock_hz / (2 * ratio) as a right shift
  function automatic logic [3:0] prescale_shift(logic [1:0] idx);
    logic [3:0] s;
    case (idx)
      2'd0:    s = 4'd1;
      2'd1:    s = 4'd4;
      2'd2:    s = 4'd7;
      default: s = 4'd9;
    endcase
    return s;
  endfunction

endpackage

>>> hw/rtl/ptif_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ptif_div import ptif_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_BITS = $clog2(DIVD_W);

  logic                busy;
  logic                done;
  logic [CNT_BITS-1:0] cnt;
  logic [DIVS_W-1:0]   rem;
  logic [DIVD_W-1:0]   quo;
  logic [DIVS_W-1:0]   dvs;

  logic [DIVS_W:0]     shifted;
  logic                ge;
  logic [DIVS_W:0]     diff;

  always_comb begin
    shifted = {rem, quo[DIVD_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CNT_BITS'(DIVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      // remainder stays below the divisor, so the top bit drops
      rem <= ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
      quo <= {quo[DIVD_W-2:0], ge};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

>>> hw/rtl/period_timer_with_interval_fit.sv
// Period timer, one item in flight: most commands pass through ST_ELAPSED, which raises out_valid once
// the output is free, then return to ST_IDLE for the next item; set interval runs up to five divides.
// Step table is rebuilt by the shared divider after reset and every clock_hz write,
// with in_ready low meanwhile. One shared 20x17 multiplier forms the products.
// Synchronous active-high reset; clock_hz resets to 40000000, period to all ones.
module period_timer_with_interval_fit import ptif_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CLK_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [CLK_W-1:0]    clock_hz;
  logic [STEP_W-1:0]   step_tbl [4];
  logic [1:0]          tbl_idx;
  logic [2:0]          try_cnt;
  logic [US_W-1:0]     us_reg;
  logic [MUL_B_W-1:0]  fit_steps;
  logic [OUT_US_W-1:0] actual_reg;

  logic [CNT_W-1:0]    timer_count;
  logic [CNT_W-1:0]    period_value;
  logic [1:0]          prescale_index;
  logic [7:0]          prescale_counter;
  logic                running;
  logic                expired_flag;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [CLK_W-1:0]    tbl_freq;
  logic [1:0]          fit_idx;
  logic [STEP_W-1:0]   fit_step;
  logic                fit_ok;
  logic [MUL_B_W-1:0]  steps_fit;
  logic                out_free;
  logic                in_xfer;
  logic                cfg_xfer;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  product;
  logic [MUL_P_W-1:0]  fallback_us;

  logic [8:0]          pc_inc;
  logic [1:0]          sel_clamped;

  ptif_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  always_comb begin
    tbl_freq  = clock_hz >> prescale_shift(tbl_idx);
    fit_idx   = (try_cnt == 3'd0) ? prescale_index : 2'(try_cnt - 3'd1);
    fit_step  = step_tbl[fit_idx];
    fit_ok    = div_rsp.quotient <= TIMER_SPAN;
    steps_fit = (div_rsp.quotient == '0) ? MUL_B_W'(1) : div_rsp.quotient[MUL_B_W-1:0];
    out_free  = !out_valid || out_ready;
    mul_b     = (state == ST_ACTUAL) ? fit_steps : {1'b0, timer_count};
    product   = step_tbl[prescale_index] * mul_b;
    fallback_us = MUL_P_W'(step_tbl[3]) << CNT_W;
    pc_inc    = {1'b0, prescale_counter} + 9'd1;
    if (in_data.prescaler_sel[7]) begin
      sel_clamped = 2'd0;
    end else if (in_data.prescaler_sel > 8'sd3) begin
      sel_clamped = 2'd3;
    end else begin
      sel_clamped = in_data.prescaler_sel[1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_TBL_START: begin
        if (tbl_freq == '0) begin
          state_next = (tbl_idx == 2'd3) ? ST_IDLE : ST_TBL_START;
        end else begin
          state_next = ST_TBL_WAIT;
        end
      end
      ST_TBL_WAIT: begin
        if (div_rsp.done) begin
          state_next = (tbl_idx == 2'd3) ? ST_IDLE : ST_TBL_START;
        end
      end
      ST_IDLE: begin
        if (cfg_valid) begin
          state_next = ST_TBL_START;
        end else if (in_valid) begin
          state_next = (in_data.cmd == CMD_SET_INTERVAL) ? ST_FIT_START : ST_ELAPSED;
        end
      end
      ST_FIT_START: begin
        if (fit_step == '0) begin
          state_next = (try_cnt == 3'd4) ? ST_FALLBACK : ST_FIT_START;
        end else begin
          state_next = ST_FIT_WAIT;
        end
      end
      ST_FIT_WAIT: begin
        if (div_rsp.done) begin
          if (fit_ok) begin
            state_next = ST_ACTUAL;
          end else begin
            state_next = (try_cnt == 3'd4) ? ST_FALLBACK : ST_FIT_START;
          end
        end
      end
      ST_ACTUAL:   state_next = ST_ELAPSED;
      ST_FALLBACK: state_next = ST_ELAPSED;
      ST_ELAPSED: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    cfg_ready        = (state == ST_IDLE);
    in_ready         = (state == ST_IDLE) && !cfg_valid;
    div_req.start    = ((state == ST_TBL_START) && (tbl_freq != '0)) ||
                       ((state == ST_FIT_START) && (fit_step != '0));
    if (state == ST_TBL_START) begin
      div_req.dividend = ONE_MILLION;
      div_req.divisor  = tbl_freq;
    end else begin
      div_req.dividend = us_reg;
      div_req.divisor  = DIVS_W'(fit_step);
    end
  end

  assign in_xfer  = in_valid && in_ready;
  assign cfg_xfer = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_TBL_START;
      tbl_idx   <= 2'd0;
      clock_hz  <= CLOCK_HZ_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_xfer) begin
        clock_hz <= cfg_data;
        tbl_idx  <= 2'd0;
      end else if ((state == ST_TBL_START && tbl_freq == '0) ||
                   (state == ST_TBL_WAIT && div_rsp.done)) begin
        tbl_idx <= tbl_idx + 2'd1;
      end
      if (state == ST_ELAPSED && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_TBL_START && tbl_freq == '0) begin
      step_tbl[tbl_idx] <= '0;
    end else if (state == ST_TBL_WAIT && div_rsp.done) begin
      step_tbl[tbl_idx] <= div_rsp.quotient[STEP_W-1:0];
    end
  end

  // timer state and fit bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      timer_count      <= '0;
      period_value     <= '1;
      prescale_index   <= 2'd0;
      prescale_counter <= '0;
      running          <= 1'b0;
      expired_flag     <= 1'b0;
      try_cnt          <= 3'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            case (in_data.cmd)
              CMD_TICK: begin
                if (running) begin
                  if (pc_inc < prescale_div(prescale_index)) begin
                    prescale_counter <= pc_inc[7:0];
                  end else begin
                    prescale_counter <= '0;
                    if (timer_count == period_value) begin
                      timer_count  <= '0;
                      expired_flag <= 1'b1;
                    end else begin
                      timer_count <= timer_count + 1'b1;
                    end
                  end
                end
              end
              CMD_SET_INTERVAL: try_cnt <= 3'd0;
              CMD_SET_PRESCALE: begin
                if (sel_clamped != prescale_index) begin
                  prescale_index   <= sel_clamped;
                  prescale_counter <= '0;
                end
              end
              CMD_START: running <= 1'b1;
              CMD_STOP:  running <= 1'b0;
              CMD_CLEAR: begin
                timer_count      <= '0;
                prescale_counter <= '0;
              end
              CMD_READ: ;
              default:  expired_flag <= 1'b0;
            endcase
          end
        end
        ST_FIT_START: begin
          if (fit_step == '0 && try_cnt != 3'd4) begin
            try_cnt <= try_cnt + 3'd1;
          end
        end
        ST_FIT_WAIT: begin
          if (div_rsp.done) begin
            if (fit_ok) begin
              period_value <= CNT_W'(steps_fit - 1'b1);
              if (MUL_B_W'(timer_count) > steps_fit - 1'b1) begin
                timer_count <= CNT_W'(steps_fit - 1'b1);
              end
              // any fit past the first try walked the prescaler index
              if (try_cnt != 3'd0) begin
                prescale_index   <= fit_idx;
                prescale_counter <= '0;
              end
            end else if (try_cnt != 3'd4) begin
              try_cnt <= try_cnt + 3'd1;
            end
          end
        end
        ST_FALLBACK: begin
          prescale_index   <= 2'd3;
          prescale_counter <= '0;
          period_value     <= '1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      us_reg     <= in_data.interval_us;
      actual_reg <= '0;
    end
    if (state == ST_FIT_WAIT && div_rsp.done) begin
      fit_steps <= steps_fit;
    end
    if (state == ST_ACTUAL) begin
      actual_reg <= product[OUT_US_W-1:0];
    end else if (state == ST_FALLBACK) begin
      actual_reg <= fallback_us[OUT_US_W-1:0];
    end
    if (state == ST_ELAPSED && out_free) begin
      out_data.actual_interval_us <= actual_reg;
      out_data.timer_value        <= timer_count;
      out_data.elapsed_us         <= product[OUT_US_W-1:0];
      out_data.expired            <= expired_flag;
      out_data.prescale_sel_now   <= prescale_index;
      out_data.period_now         <= period_value;
    end
  end

endmodule
